>>> sv/bmft_pkg.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation package
// Transaction payload types, command and fault codes, and the control and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmft_pkg;

  // Flash command codes on the result channel.
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_COPY    = 3'd1;
  localparam logic [2:0] CMD_PROGRAM = 3'd2;
  localparam logic [2:0] CMD_ERASE   = 3'd3;
  localparam logic [2:0] CMD_REJECT  = 3'd4;

  // Fault codes.
  localparam logic [1:0] FLT_NONE     = 2'd0;
  localparam logic [1:0] FLT_BAD_SECT = 2'd1;
  localparam logic [1:0] FLT_UNMAPPED = 2'd2;
  localparam logic [1:0] FLT_NO_FREE  = 2'd3;

  // Request opcodes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result kinds that the controller asks the datapath to form.
  localparam logic [2:0] RES_BAD        = 3'd0;
  localparam logic [2:0] RES_UNMAPPED   = 3'd1;
  localparam logic [2:0] RES_NO_FREE    = 3'd2;
  localparam logic [2:0] RES_READ       = 3'd3;
  localparam logic [2:0] RES_PROG_NEW   = 3'd4;
  localparam logic [2:0] RES_COPY       = 3'd5;
  localparam logic [2:0] RES_PROG_SPARE = 3'd6;
  localparam logic [2:0] RES_ERASE      = 3'd7;

  typedef struct packed {
    logic       opcode;
    logic [5:0] logical_sector;
  } in_t;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] source_page;
    logic [5:0] target_page;
    logic [3:0] erase_block;
    logic [1:0] fault;
    logic       last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_req;
    logic       latch_lbn;
    logic       latch_split;
    logic       scan_inc;
    logic       page_inc;
    logic       emit;
    logic [2:0] res_sel;
    logic       upd_new;
    logic       upd_swap;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bad;
    logic is_write;
    logic mapped;
    logic cand_free;
    logic scan_last;
    logic need_copy;
    logic page_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/block_mapped_flash_translation.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation, top level
// A read or reject is loaded from the decide state, after the sector split; a first write
// once the free-flag scan reaches the block chosen (the last one scanned if none is free);
// an overwrite's erase after the page-by-page copy walk and the program into the spare.
// A new request is accepted only once the last result of the one before has been loaded.
// Reset empties every mapping and frees every block; the spare block is block 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One request transaction is taken at a time. The controller walks the request
// through a sequence of states: the sector is split into a logical block
// and a page offset in the DIV and SPLIT states (a reciprocal multiply, then the
// remainder), the mapping tables are read, and the result transactions are
// formed one at a time into a single output register. The input side becomes
// ready again as soon as the last result has been loaded, so the next request
// may be accepted while that result still waits on the result channel.
//
// A first write scans the free flags one block a cycle, from block 0 upwards,
// skipping the spare. An overwrite walks every page offset of the block in
// turn, issuing a copy for each other written page, then programs the new
// page into the spare and erases the old block, after which the two trade
// roles. Any cycle in which a result is due while the output register is full
// and not being taken simply holds the sequence where it stands.

module block_mapped_flash_translation import bmft_pkg::*; #(
  parameter int PAGES_PER_BLK  = 4,
  parameter int PHYS_BLOCKS    = 16,
  parameter int LOGICAL_BLOCKS = 15
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Command and status bundles between the two halves.
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The controller decides the order of commands; it never sees addresses.
  bmft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the tables and forms every result transaction.
  bmft_dp #(
    .PAGES_PER_BLK  (PAGES_PER_BLK),
    .PHYS_BLOCKS    (PHYS_BLOCKS),
    .LOGICAL_BLOCKS (LOGICAL_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/bmft_ctrl.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation controller
// Sequences one request at a time and tells the datapath what to latch,
// which result to form and which mapping update to commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmft_ctrl import bmft_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SPLIT  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_COPY   = 3'd5;
  localparam logic [2:0] ST_PROG   = 3'd6;
  localparam logic [2:0] ST_ERASE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = RES_BAD;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.latch_lbn = 1'b1;
        state_nxt     = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.latch_split = 1'b1;
        state_nxt       = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.bad) begin
          cmd.res_sel = RES_BAD;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!sts.is_write) begin
          cmd.res_sel = sts.mapped ? RES_READ : RES_UNMAPPED;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (!sts.mapped) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_COPY;
        end
      end
      ST_SCAN: begin
        if (sts.cand_free) begin
          cmd.res_sel = RES_PROG_NEW;
          if (sts.out_free) begin
            cmd.emit    = 1'b1;
            cmd.upd_new = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (sts.scan_last) begin
          cmd.res_sel = RES_NO_FREE;
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_COPY: begin
        cmd.res_sel = RES_COPY;
        if (!sts.need_copy || sts.out_free) begin
          cmd.emit = sts.need_copy;
          if (sts.page_last) begin
            state_nxt = ST_PROG;
          end else begin
            cmd.page_inc = 1'b1;
          end
        end
      end
      ST_PROG: begin
        cmd.res_sel = RES_PROG_SPARE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_ERASE;
        end
      end
      ST_ERASE: begin
        cmd.res_sel = RES_ERASE;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.upd_swap = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bmft_dp.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation datapath
// Holds the mapping tables, the spare block and the request registers, forms
// page addresses and result transactions, and owns the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmft_dp import bmft_pkg::*; #(
  parameter int PAGES_PER_BLK  = 4,
  parameter int PHYS_BLOCKS    = 16,
  parameter int LOGICAL_BLOCKS = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  ctl_cmd_t cmd,
  output dp_sts_t  sts,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  // Only sectors 0..63 exist, so only this many logical blocks are reachable.
  localparam int NLB_REACH = 63 / PAGES_PER_BLK + 1;
  localparam int NLB   = (LOGICAL_BLOCKS < NLB_REACH) ? LOGICAL_BLOCKS : NLB_REACH;
  localparam int LW    = (NLB > 1) ? $clog2(NLB) : 1;
  // The lowest free block always lies below NLB + 1, as at most NLB blocks
  // (mapped ones and the spare) are ever occupied.
  localparam int NCAND = (PHYS_BLOCKS < NLB + 1) ? PHYS_BLOCKS : NLB + 1;
  localparam int BW    = (NCAND > 1) ? $clog2(NCAND) : 1;
  localparam int OW    = $clog2(PAGES_PER_BLK);
  localparam int PGW   = BW + OW;
  localparam int PGX   = (PGW > 6) ? PGW : 6;
  localparam int EW    = (BW > 4) ? BW : 4;
  localparam int SH    = 6 + OW;
  localparam int RECIP = ((1 << SH) + PAGES_PER_BLK - 1) / PAGES_PER_BLK;
  localparam int PRW   = SH + 7;
  localparam int LIMIT = LOGICAL_BLOCKS * PAGES_PER_BLK;

  logic                     op_r;
  logic [5:0]               lsn_r;
  logic                     bad_r;
  logic [5:0]               lbn_r;
  logic [OW-1:0]            off_r;
  logic                     mapped_r;
  logic [BW-1:0]            pbn_r;
  logic [PAGES_PER_BLK-1:0] wr_r;
  logic [BW-1:0]            scan_r;
  logic [OW-1:0]            page_r;
  logic [BW-1:0]            spare_r;
  logic [BW-1:0]            map_blk_r   [NLB];
  logic                     map_vld_r   [NLB];
  logic [PAGES_PER_BLK-1:0] wpages_r    [NLB];
  logic                     in_use_r    [NCAND];
  logic                     out_valid_r;
  out_t                     out_data_r;

  logic [PRW-1:0] quot_prod;
  logic [11:0]    rem_diff;
  logic [LW-1:0]  lidx;
  logic           lbn_ok;
  out_t           res;

  function automatic logic [5:0] page_addr(input logic [BW-1:0] blk,
                                           input logic [OW-1:0] ofs);
    logic [PGX-1:0] t;
    t = PGX'(blk) * PGX'(PAGES_PER_BLK) + PGX'(ofs);
    return t[5:0];
  endfunction

  function automatic logic [3:0] blk_field(input logic [BW-1:0] blk);
    logic [EW-1:0] t;
    t = EW'(blk);
    return t[3:0];
  endfunction

  // Sector split: quotient by reciprocal multiplication, exact for 6-bit
  // sectors, then the remainder from the registered quotient.
  assign quot_prod = PRW'(lsn_r) * PRW'(RECIP);
  assign rem_diff  = 12'(lsn_r) - 12'(lbn_r) * 12'(PAGES_PER_BLK);
  assign lidx      = lbn_r[LW-1:0];
  assign lbn_ok    = (lbn_r < 6'(NLB));

  assign sts.bad       = bad_r;
  assign sts.is_write  = (op_r == OP_WRITE);
  assign sts.mapped    = mapped_r;
  assign sts.cand_free = !in_use_r[scan_r] && (scan_r != spare_r);
  assign sts.scan_last = (scan_r == BW'(NCAND - 1));
  assign sts.need_copy = wr_r[page_r] && (page_r != off_r);
  assign sts.page_last = (page_r == OW'(PAGES_PER_BLK - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    unique case (cmd.res_sel)
      RES_BAD: begin
        res.command = CMD_REJECT;
        res.fault   = FLT_BAD_SECT;
      end
      RES_UNMAPPED: begin
        res.command = CMD_REJECT;
        res.fault   = FLT_UNMAPPED;
      end
      RES_NO_FREE: begin
        res.command = CMD_REJECT;
        res.fault   = FLT_NO_FREE;
      end
      RES_READ: begin
        res.command     = CMD_READ;
        res.source_page = page_addr(pbn_r, off_r);
      end
      RES_PROG_NEW: begin
        res.command     = CMD_PROGRAM;
        res.target_page = page_addr(scan_r, off_r);
      end
      RES_COPY: begin
        res.command     = CMD_COPY;
        res.source_page = page_addr(pbn_r, page_r);
        res.target_page = page_addr(spare_r, page_r);
        res.last        = 1'b0;
      end
      RES_PROG_SPARE: begin
        res.command     = CMD_PROGRAM;
        res.target_page = page_addr(spare_r, off_r);
        res.last        = 1'b0;
      end
      RES_ERASE: begin
        res.command     = CMD_ERASE;
        res.erase_block = blk_field(pbn_r);
      end
      default: begin
        res.command = CMD_REJECT;
      end
    endcase
  end

  // Request registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_data.opcode;
      lsn_r <= in_data.logical_sector;
      bad_r <= (int'(in_data.logical_sector) >= LIMIT);
    end
    if (cmd.latch_lbn) begin
      lbn_r <= quot_prod[SH+5:SH];
    end
    if (cmd.latch_split) begin
      off_r    <= rem_diff[OW-1:0];
      mapped_r <= lbn_ok ? map_vld_r[lidx] : 1'b0;
      pbn_r    <= lbn_ok ? map_blk_r[lidx] : '0;
      wr_r     <= lbn_ok ? wpages_r[lidx] : '0;
      scan_r   <= '0;
      page_r   <= '0;
    end else begin
      if (cmd.scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.page_inc) begin
        page_r <= page_r + 1'b1;
      end
    end
    if (cmd.upd_new) begin
      map_blk_r[lidx] <= scan_r;
    end else if (cmd.upd_swap) begin
      map_blk_r[lidx] <= spare_r;
    end
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  // Mapping state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spare_r <= '0;
      for (int i = 0; i < NLB; i++) begin
        map_vld_r[i] <= 1'b0;
        wpages_r[i]  <= '0;
      end
      for (int i = 0; i < NCAND; i++) begin
        in_use_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.upd_new) begin
        map_vld_r[lidx]       <= 1'b1;
        in_use_r[scan_r]      <= 1'b1;
        wpages_r[lidx][off_r] <= 1'b1;
      end else if (cmd.upd_swap) begin
        in_use_r[pbn_r]       <= 1'b0;
        in_use_r[spare_r]     <= 1'b1;
        spare_r               <= pbn_r;
        wpages_r[lidx][off_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/bmft_checker.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation checker
// Port-level properties of the translation block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmft_checker import bmft_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A request is worked on alone: no second accept right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted request");

  // Rejects, reads and erases always close a request.
  a_closing_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == CMD_REJECT || out_data.command == CMD_READ ||
                  out_data.command == CMD_ERASE) |-> out_data.last)
    else $error("closing command without last");

  // A fault is only ever reported on a reject.
  a_fault_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault != FLT_NONE) |-> out_data.command == CMD_REJECT)
    else $error("fault on a non-reject command");

endmodule

bind block_mapped_flash_translation bmft_checker u_bmft_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Block-mapped flash translation testbench
// Drives read and write request transactions into the translation block and
// checks every flash command transaction that comes back against a predictor
// that keeps its own copy of the mapping tables, the spare block and the
// written-page bitmaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bmft_pkg::*;

  // Geometry of the block under test.
  localparam int PPB   = 4;
  localparam int PHYS  = 16;
  localparam int LBLKS = 15;

  // Random request count, and the settling time after the last command.
  localparam int RANDOM_REQS  = 200;
  localparam int SETTLE_TICKS = 20;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  block_mapped_flash_translation #(
    .PAGES_PER_BLK (PPB),
    .PHYS_BLOCKS   (PHYS),
    .LOGICAL_BLOCKS(LBLKS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and the flash commands the predictor
  // expects, oldest first.
  in_t  pending_reqs[$];
  out_t expected_cmds[$];
  int   reqs_queued   = 0;
  int   reqs_accepted = 0;
  int   error_count   = 0;

  // Neither side idles while this stretch of requests goes through, so that
  // back-to-back transactions are exercised as well.
  wire  no_idle = (reqs_accepted >= 90) && (reqs_accepted < 150);

  // Predictor state, mirroring the translation tables of the block.
  logic [3:0] map_phys [LBLKS];
  logic       map_valid[LBLKS];
  logic       phys_busy[PHYS];
  logic [3:0] spare_phys;
  logic [3:0] page_bits[LBLKS];

  // Every reject transaction carries only its fault code and the last flag.
  function automatic out_t reject_cmd(logic [1:0] why);
    out_t r;
    r       = '0;
    r.command = CMD_REJECT;
    r.fault   = why;
    r.last    = 1'b1;
    return r;
  endfunction

  // Works out the flash commands that one request causes, queues them, and
  // brings the mapping tables up to date.
  function automatic void translate_request(in_t req);
    int   lbn;
    int   off;
    int   free_blk;
    int   old_blk;
    out_t r;
    if (int'(req.logical_sector) >= LBLKS * PPB) begin
      expected_cmds.push_back(reject_cmd(FLT_BAD_SECT));
      return;
    end
    lbn = int'(req.logical_sector) / PPB;
    off = int'(req.logical_sector) % PPB;

    if (req.opcode == OP_READ) begin
      if (!map_valid[lbn]) begin
        expected_cmds.push_back(reject_cmd(FLT_UNMAPPED));
      end else begin
        // An unwritten page of a mapped block is still read: it holds erased
        // content.
        r             = '0;
        r.command     = CMD_READ;
        r.source_page = 6'(int'(map_phys[lbn]) * PPB + off);
        r.last        = 1'b1;
        expected_cmds.push_back(r);
      end
      return;
    end

    if (!map_valid[lbn]) begin
      // A first write claims the lowest free block that is not the spare.
      free_blk = -1;
      for (int b = 0; b < PHYS; b++) begin
        if (free_blk < 0 && !phys_busy[b] && b != int'(spare_phys)) free_blk = b;
      end
      if (free_blk < 0) begin
        expected_cmds.push_back(reject_cmd(FLT_NO_FREE));
        return;
      end
      map_phys[lbn]       = 4'(free_blk);
      map_valid[lbn]      = 1'b1;
      phys_busy[free_blk] = 1'b1;
      page_bits[lbn][off] = 1'b1;
      r             = '0;
      r.command     = CMD_PROGRAM;
      r.target_page = 6'(free_blk * PPB + off);
      r.last        = 1'b1;
      expected_cmds.push_back(r);
      return;
    end

    // An overwrite moves the other written pages into the spare, programs the
    // new page there and erases the old block; the two then trade roles.
    old_blk = int'(map_phys[lbn]);
    for (int p = 0; p < PPB; p++) begin
      if (p != off && page_bits[lbn][p]) begin
        r             = '0;
        r.command     = CMD_COPY;
        r.source_page = 6'(old_blk * PPB + p);
        r.target_page = 6'(int'(spare_phys) * PPB + p);
        expected_cmds.push_back(r);
      end
    end
    r             = '0;
    r.command     = CMD_PROGRAM;
    r.target_page = 6'(int'(spare_phys) * PPB + off);
    expected_cmds.push_back(r);
    r             = '0;
    r.command     = CMD_ERASE;
    r.erase_block = 4'(old_blk);
    r.last        = 1'b1;
    expected_cmds.push_back(r);

    phys_busy[old_blk]         = 1'b0;
    phys_busy[int'(spare_phys)] = 1'b1;
    map_phys[lbn]              = spare_phys;
    spare_phys                 = 4'(old_blk);
    page_bits[lbn][off]        = 1'b1;
  endfunction

  function automatic void queue_req(logic op, int sector);
    in_t req;
    req.opcode         = op;
    req.logical_sector = 6'(sector);
    pending_reqs.push_back(req);
    reqs_queued++;
  endfunction

  // Driver: the predictor sees each request at the edge where it is taken.
  // A new request is only offered once the current one has gone, so valid is
  // never withdrawn while it waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        translate_request(in_data);
        reqs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: each command transaction taken from the block is compared with
  // the oldest expectation, field by field.
  out_t want_cmd;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command transaction, expected none, actual %p",
                   $time, out_data);
          error_count++;
        end else begin
          want_cmd = expected_cmds.pop_front();
          check_field("command",     int'(want_cmd.command),     int'(out_data.command));
          check_field("source_page", int'(want_cmd.source_page), int'(out_data.source_page));
          check_field("target_page", int'(want_cmd.target_page), int'(out_data.target_page));
          check_field("erase_block", int'(want_cmd.erase_block), int'(out_data.erase_block));
          check_field("fault",       int'(want_cmd.fault),       int'(out_data.fault));
          check_field("last",        int'(want_cmd.last),        int'(out_data.last));
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  // Stimulus and end of run.
  initial begin
    // The predictor starts from the reset state of the block.
    spare_phys = '0;
    for (int i = 0; i < LBLKS; i++) begin
      map_phys[i]  = '0;
      map_valid[i] = 1'b0;
      page_bits[i] = '0;
    end
    for (int i = 0; i < PHYS; i++) phys_busy[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: an unmapped read, bad sectors on both operations,
    // first writes, an overwrite with nothing to copy, an overwrite that
    // copies every other page, and a read of an unwritten page.
    queue_req(OP_READ,  0);
    queue_req(OP_READ,  63);
    queue_req(OP_WRITE, 60);
    queue_req(OP_WRITE, 59);
    queue_req(OP_WRITE, 0);
    queue_req(OP_READ,  3);
    queue_req(OP_WRITE, 0);
    queue_req(OP_WRITE, 1);
    queue_req(OP_WRITE, 2);
    queue_req(OP_WRITE, 3);
    queue_req(OP_WRITE, 0);
    queue_req(OP_READ,  0);
    queue_req(OP_WRITE, 56);
    queue_req(OP_READ,  59);
    // First writes to every remaining logical block, so that the whole of
    // the physical array ends up in use.
    for (int b = 1; b < LBLKS - 1; b++) queue_req(OP_WRITE, b * PPB + (b % PPB));

    // The sender pauses here until every expected command has arrived.
    while (reqs_accepted < reqs_queued || expected_cmds.size() > 0) @(posedge clk);

    // Random requests: mostly in-range sectors, with a share of bad ones.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(9) == 0) queue_req(1'($urandom), $urandom_range(63, LBLKS * PPB));
      else queue_req(1'($urandom), $urandom_range(LBLKS * PPB - 1, 0));
    end

    while (reqs_accepted < reqs_queued || expected_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (error_count == 0 && expected_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/bmft_pkg.sv
sv/bmft_ctrl.sv
sv/bmft_dp.sv
sv/block_mapped_flash_translation.sv
sv/bmft_checker.sv
tb/testbench.sv
